// ===== src/sha1_pkg.sv =====
`default_nettype none

package sha1_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned DigestWords = 5;
  localparam int unsigned WordIdxW    = 3;
  localparam logic [WordIdxW-1:0] LastWordIdx = WordIdxW'(DigestWords - 1);

  localparam word_t InitChain [DigestWords] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [7:0] PadMarker = 8'h80;

  // round groups of twenty rounds each
  localparam logic [1:0] GrpChoose   = 2'd0;
  localparam logic [1:0] GrpParity   = 2'd1;
  localparam logic [1:0] GrpMajority = 2'd2;
  localparam logic [1:0] GrpParity2  = 2'd3;

  function automatic word_t round_k(input logic [1:0] grp);
    word_t k;
    case (grp)
      GrpChoose:   k = 32'h5A827999;
      GrpParity:   k = 32'h6ED9EBA1;
      GrpMajority: k = 32'h8F1BBCDC;
      default:     k = 32'hCA62C1D6;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== src/sha1_message_digest.sv =====
// channel | direction | handshake                 | payload
// --------+-----------+---------------------------+------------------------------------------
// in      | sink      | in_valid_i / in_stall_o   | data_byte_i, has_byte_i, end_of_message_i
// out     | source    | out_valid_o / out_stall_i | digest_word_o, word_number_o, last_word_o
//
// A word that neither completes a block nor ends the message leaves the sequencer idle. The word
// holding the 64th byte of a block starts 80 rounds through the single round unit and then the
// chaining update. A final word adds padding bytes at one per cycle (9 to 72), the rounds and
// chaining update of each padded block, and 5 digest words at one per cycle when out_stall_i is low.
// rst_ni clears the sequencer and loads the initial chaining words at once.
// in_stall_o is high from the word that starts a block or padding until the block is
// idle again; a stalled digest word holds until taken.

`default_nettype none

module sha1_message_digest
  import sha1_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                has_byte_i,
  input  wire logic                end_of_message_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [31:0]              digest_word_o,
  output logic [WordIdxW-1:0]      word_number_o,
  output logic                     last_word_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPad   = 3'd1;
  localparam logic [2:0] StRound = 3'd2;
  localparam logic [2:0] StFinal = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  localparam logic [5:0] FillLast  = 6'd63;
  localparam logic [5:0] FillLenAt = 6'd56;
  localparam logic [6:0] RoundLast = 7'd79;

  logic [2:0]          state_q, state_d;
  logic [5:0]          fill_q, fill_d;
  logic [60:0]         len_q, len_d;
  logic                pad_q, pad_d;
  logic                mark_q, mark_d;
  logic                len_act_q, len_act_d;
  logic                done_q, done_d;
  logic [WordIdxW-1:0] out_idx_q, out_idx_d;
  logic [6:0]          rnd_q, rnd_d;
  word_t               chain_q [DigestWords];
  word_t               chain_d [DigestWords];
  word_t               win_q [16];
  word_t               win_d [16];
  word_t               a_q, b_q, c_q, d_q, e_q;
  word_t               a_d, b_d, c_d, d_d, e_d;
  logic [23:0]         acc_q, acc_d;
  logic [63:0]         bits_q, bits_d;

  logic                put_en;
  logic [7:0]          put_byte;
  logic [1:0]          grp;
  word_t               f_val;
  word_t               t_val;
  word_t               w_new;
  logic [60:0]         len_inc;

  assign len_inc = len_q + 61'd1;

  always_comb begin
    if (rnd_q < 7'd20) begin
      grp = GrpChoose;
    end else if (rnd_q < 7'd40) begin
      grp = GrpParity;
    end else if (rnd_q < 7'd60) begin
      grp = GrpMajority;
    end else begin
      grp = GrpParity2;
    end
  end

  always_comb begin
    case (grp)
      GrpChoose:   f_val = (b_q & c_q) | (~b_q & d_q);
      GrpMajority: f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      default:     f_val = b_q ^ c_q ^ d_q;
    endcase
  end

  assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + round_k(grp) + win_q[0];

  // next schedule word from the fixed taps of the 16-word line
  always_comb begin
    word_t x;
    x = win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0];
    w_new = {x[30:0], x[31]};
  end

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    len_d     = len_q;
    pad_d     = pad_q;
    mark_d    = mark_q;
    len_act_d = len_act_q;
    done_d    = done_q;
    out_idx_d = out_idx_q;
    rnd_d     = rnd_q;
    chain_d   = chain_q;
    win_d     = win_q;
    a_d       = a_q;
    b_d       = b_q;
    c_d       = c_q;
    d_d       = d_q;
    e_d       = e_q;
    acc_d     = acc_q;
    bits_d    = bits_q;
    put_en    = 1'b0;
    put_byte  = data_byte_i;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          put_en = has_byte_i;
          if (has_byte_i) begin
            len_d = len_inc;
          end
          if (end_of_message_i) begin
            pad_d  = 1'b1;
            mark_d = 1'b1;
            len_d  = '0;
            bits_d = {(has_byte_i ? len_inc : len_q), 3'b000};
          end
          if (has_byte_i && fill_q == FillLast) begin
            state_d = StRound;
          end else if (end_of_message_i) begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        put_en = 1'b1;
        if (mark_q) begin
          put_byte = PadMarker;
          mark_d   = 1'b0;
        end else if (!len_act_q && fill_q != FillLenAt) begin
          put_byte = 8'h00;
        end else begin
          put_byte  = bits_q[63:56];
          bits_d    = {bits_q[55:0], 8'h00};
          len_act_d = 1'b1;
          if (fill_q == FillLast) begin
            done_d = 1'b1;
          end
        end
        if (fill_q == FillLast) begin
          state_d = StRound;
        end
      end
      StRound: begin
        e_d = d_q;
        d_d = c_q;
        c_d = {b_q[1:0], b_q[31:2]};
        b_d = a_q;
        a_d = t_val;
        for (int k = 0; k < 15; k++) begin
          win_d[k] = win_q[k+1];
        end
        win_d[15] = w_new;
        if (rnd_q == RoundLast) begin
          rnd_d   = '0;
          state_d = StFinal;
        end else begin
          rnd_d = rnd_q + 7'd1;
        end
      end
      StFinal: begin
        chain_d[0] = chain_q[0] + a_q;
        chain_d[1] = chain_q[1] + b_q;
        chain_d[2] = chain_q[2] + c_q;
        chain_d[3] = chain_q[3] + d_q;
        chain_d[4] = chain_q[4] + e_q;
        if (done_q) begin
          state_d = StOut;
        end else if (pad_q) begin
          state_d = StPad;
        end else begin
          state_d = StIdle;
        end
      end
      StOut: begin
        if (!out_stall_i) begin
          for (int k = 0; k < DigestWords - 1; k++) begin
            chain_d[k] = chain_q[k+1];
          end
          out_idx_d = out_idx_q + WordIdxW'(1);
          if (out_idx_q == LastWordIdx) begin
            // re-arm for the next message
            chain_d   = InitChain;
            out_idx_d = '0;
            pad_d     = 1'b0;
            len_act_d = 1'b0;
            done_d    = 1'b0;
            state_d   = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // bytes pack big-endian into words, full words shift into the line
    if (put_en) begin
      fill_d = fill_q + 6'd1;
      if (fill_q[1:0] == 2'd3) begin
        for (int k = 0; k < 15; k++) begin
          win_d[k] = win_q[k+1];
        end
        win_d[15] = {acc_q, put_byte};
      end else begin
        acc_d = {acc_q[15:0], put_byte};
      end
      if (fill_q == FillLast) begin
        a_d = chain_q[0];
        b_d = chain_q[1];
        c_d = chain_q[2];
        d_d = chain_q[3];
        e_d = chain_q[4];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      fill_q    <= '0;
      len_q     <= '0;
      pad_q     <= 1'b0;
      mark_q    <= 1'b0;
      len_act_q <= 1'b0;
      done_q    <= 1'b0;
      out_idx_q <= '0;
      rnd_q     <= '0;
      chain_q   <= InitChain;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      len_q     <= len_d;
      pad_q     <= pad_d;
      mark_q    <= mark_d;
      len_act_q <= len_act_d;
      done_q    <= done_d;
      out_idx_q <= out_idx_d;
      rnd_q     <= rnd_d;
      chain_q   <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q  <= win_d;
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    d_q    <= d_d;
    e_q    <= e_d;
    acc_q  <= acc_d;
    bits_q <= bits_d;
  end

  assign in_stall_o    = (state_q != StIdle);
  assign out_valid_o   = (state_q == StOut);
  assign digest_word_o = chain_q[0];
  assign word_number_o = out_idx_q;
  assign last_word_o   = (out_idx_q == LastWordIdx);

endmodule

`default_nettype wire

// ===== src/sha1_checker.sv =====
`default_nettype none

module sha1_checker
  import sha1_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                end_of_message_i,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic [31:0]         digest_word_o,
  input wire logic [WordIdxW-1:0] word_number_o,
  input wire logic                last_word_o
);

  // no new word is taken while the digest is being delivered
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken during digest output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(digest_word_o)
      && $stable(word_number_o))
    else $error("stalled digest word changed");

  // digest words come in order, the last flagged at index four
  a_word_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_word_o |=> out_valid_o
      && word_number_o == $past(word_number_o) + WordIdxW'(1))
    else $error("digest word skipped or repeated");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_number_o == LastWordIdx)))
    else $error("last flag on wrong digest word");

  // a word that does not end the message never brings a digest right after it
  a_no_early_digest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !end_of_message_i |=> !out_valid_o)
    else $error("digest without end of message");

endmodule

bind sha1_message_digest sha1_checker u_checker (.*);

`default_nettype wire
